// ----- rtl/bsc_pkg.sv -----
// Shared constants, types and the microcode table of the safety check.
package bsc_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int MAX_RESOURCES = 8;
    localparam int COUNT_BITS    = 16;

    localparam int PROC_BITS  = $clog2(MAX_PROCESSES);
    localparam int RES_BITS   = $clog2(MAX_RESOURCES);
    localparam int ADDR_BITS  = PROC_BITS + RES_BITS;
    localparam int DONE_BITS  = PROC_BITS + 1;
    localparam int NEED_BITS  = COUNT_BITS + 1;
    localparam int AVAIL_BITS = COUNT_BITS + 8;
    localparam int ENTRY_BITS = NEED_BITS + COUNT_BITS;
    localparam int STORE_DEPTH = MAX_PROCESSES * MAX_RESOURCES;

    localparam int CMD_BITS       = 2;
    localparam int NPROC_CFG_BITS = 5;
    localparam int NRES_CFG_BITS  = 4;
    localparam int CFG_DATA_BITS  = 5;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CMD_BITS-1:0] CMD_LOAD_AVAIL = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_LOAD_PAIR  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_RUN        = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_PROCESSES = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_RESOURCES = 1'd1;

    localparam logic [NPROC_CFG_BITS-1:0] NPROC_RESET = 5'd16;
    localparam logic [NRES_CFG_BITS-1:0]  NRES_RESET  = 4'd8;

    localparam int UPC_BITS  = 5;
    localparam int UOP_BITS  = 4;
    localparam int COND_BITS = 4;

    typedef logic [UPC_BITS-1:0]  upc_t;
    typedef logic [UOP_BITS-1:0]  uop_t;
    typedef logic [COND_BITS-1:0] cond_t;

    // Datapath micro-operations.
    localparam uop_t OP_NOP        = 4'd0;
    localparam uop_t OP_INIT       = 4'd1;
    localparam uop_t OP_HOLD_ACC   = 4'd2;
    localparam uop_t OP_HOLD_END   = 4'd3;
    localparam uop_t OP_PASS_START = 4'd4;
    localparam uop_t OP_FIT_ACC    = 4'd5;
    localparam uop_t OP_RELEASE    = 4'd6;
    localparam uop_t OP_FINISH     = 4'd7;
    localparam uop_t OP_NEXT_I     = 4'd8;
    localparam uop_t OP_OUT_INIT   = 4'd9;
    localparam uop_t OP_EMIT_SEQ   = 4'd10;
    localparam uop_t OP_EMIT_DEAD  = 4'd11;

    // Jump conditions.
    localparam cond_t C_NEXT     = 4'd0;
    localparam cond_t C_ALWAYS   = 4'd1;
    localparam cond_t C_NO_RUN   = 4'd2;
    localparam cond_t C_J_NLAST  = 4'd3;
    localparam cond_t C_I_NLAST  = 4'd4;
    localparam cond_t C_DONE_ALL = 4'd5;
    localparam cond_t C_FIN_I    = 4'd6;
    localparam cond_t C_NFLAG    = 4'd7;
    localparam cond_t C_PROGRESS = 4'd8;
    localparam cond_t C_STALL    = 4'd9;
    localparam cond_t C_MORE     = 4'd10;

    // Program steps.
    localparam upc_t S_IDLE   = 5'd0;
    localparam upc_t S_INIT   = 5'd1;
    localparam upc_t S_A_RD   = 5'd2;
    localparam upc_t S_A_ACC  = 5'd3;
    localparam upc_t S_A_END  = 5'd4;
    localparam upc_t S_B_PASS = 5'd5;
    localparam upc_t S_B_SKIP = 5'd6;
    localparam upc_t S_B_RD   = 5'd7;
    localparam upc_t S_B_FIT  = 5'd8;
    localparam upc_t S_B_CHK  = 5'd9;
    localparam upc_t S_B_RD2  = 5'd10;
    localparam upc_t S_B_REL  = 5'd11;
    localparam upc_t S_B_FIN  = 5'd12;
    localparam upc_t S_B_NEXT = 5'd13;
    localparam upc_t S_B_END  = 5'd14;
    localparam upc_t S_D_EMIT = 5'd15;
    localparam upc_t S_D_DONE = 5'd16;
    localparam upc_t S_E_INIT = 5'd17;
    localparam upc_t S_E_EMIT = 5'd18;
    localparam upc_t S_E_MORE = 5'd19;
    localparam upc_t S_E_DONE = 5'd20;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  target;
    } ctrl_word_t;

    typedef struct packed {
        uop_t op;
        logic idle;
    } ctrl_t;

    typedef struct packed {
        logic run_start;
        logic j_last;
        logic i_last;
        logic flag;
        logic fin_i;
        logic done_all;
        logic progress;
        logic out_stall;
        logic more;
    } stat_t;

    function automatic ctrl_word_t bsc_word(input uop_t op, input cond_t cond,
                                            input upc_t target);
        ctrl_word_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // The control store: one word per step.
    function automatic ctrl_word_t bsc_rom(input upc_t addr);
        ctrl_word_t w;
        unique case (addr)
            S_IDLE:   w = bsc_word(OP_NOP,        C_NO_RUN,   S_IDLE);
            S_INIT:   w = bsc_word(OP_INIT,       C_NEXT,     S_IDLE);
            S_A_RD:   w = bsc_word(OP_NOP,        C_NEXT,     S_IDLE);
            S_A_ACC:  w = bsc_word(OP_HOLD_ACC,   C_J_NLAST,  S_A_RD);
            S_A_END:  w = bsc_word(OP_HOLD_END,   C_I_NLAST,  S_A_RD);
            S_B_PASS: w = bsc_word(OP_PASS_START, C_DONE_ALL, S_E_INIT);
            S_B_SKIP: w = bsc_word(OP_NOP,        C_FIN_I,    S_B_NEXT);
            S_B_RD:   w = bsc_word(OP_NOP,        C_NEXT,     S_IDLE);
            S_B_FIT:  w = bsc_word(OP_FIT_ACC,    C_J_NLAST,  S_B_RD);
            S_B_CHK:  w = bsc_word(OP_NOP,        C_NFLAG,    S_B_NEXT);
            S_B_RD2:  w = bsc_word(OP_NOP,        C_NEXT,     S_IDLE);
            S_B_REL:  w = bsc_word(OP_RELEASE,    C_J_NLAST,  S_B_RD2);
            S_B_FIN:  w = bsc_word(OP_FINISH,     C_NEXT,     S_IDLE);
            S_B_NEXT: w = bsc_word(OP_NEXT_I,     C_I_NLAST,  S_B_SKIP);
            S_B_END:  w = bsc_word(OP_NOP,        C_PROGRESS, S_B_PASS);
            S_D_EMIT: w = bsc_word(OP_EMIT_DEAD,  C_STALL,    S_D_EMIT);
            S_D_DONE: w = bsc_word(OP_NOP,        C_ALWAYS,   S_IDLE);
            S_E_INIT: w = bsc_word(OP_OUT_INIT,   C_NEXT,     S_IDLE);
            S_E_EMIT: w = bsc_word(OP_EMIT_SEQ,   C_STALL,    S_E_EMIT);
            S_E_MORE: w = bsc_word(OP_NOP,        C_MORE,     S_E_EMIT);
            S_E_DONE: w = bsc_word(OP_NOP,        C_ALWAYS,   S_IDLE);
            default:  w = bsc_word(OP_NOP,        C_ALWAYS,   S_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/bsc_if.sv -----
// Valid/ready channel interfaces for commands and results.
interface bsc_in_if;
    import bsc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_BITS-1:0]   command;
    logic [PROC_BITS-1:0]  proc_index;
    logic [RES_BITS-1:0]   res_index;
    logic [COUNT_BITS-1:0] avail_count;
    logic [COUNT_BITS-1:0] max_demand;
    logic [COUNT_BITS-1:0] allocated;

    modport source (output valid, command, proc_index, res_index, avail_count,
                    max_demand, allocated, input ready);
    modport sink (input valid, command, proc_index, res_index, avail_count,
                  max_demand, allocated, output ready);
endinterface

interface bsc_out_if;
    import bsc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PROC_BITS-1:0] process_id;
    logic                 status;
    logic                 last;

    modport source (output valid, process_id, status, last, input ready);
    modport sink (input valid, process_id, status, last, output ready);
endinterface

// ----- rtl/bsc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- rtl/bsc_sequencer.sv -----
// Microcode sequencer: step counter, control store and conditional jumps.
module bsc_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  bsc_pkg::stat_t stat,
    output bsc_pkg::ctrl_t ctrl
);
    import bsc_pkg::*;

    upc_t       upc_reg;
    upc_t       upc_next;
    ctrl_word_t word;
    logic       take;

    always_comb
    begin
        word = bsc_rom(upc_reg);
        case (word.cond)
            C_NEXT:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_RUN:   take = !stat.run_start;
            C_J_NLAST:  take = !stat.j_last;
            C_I_NLAST:  take = !stat.i_last;
            C_DONE_ALL: take = stat.done_all;
            C_FIN_I:    take = stat.fin_i;
            C_NFLAG:    take = !stat.flag;
            C_PROGRESS: take = stat.progress;
            C_STALL:    take = stat.out_stall;
            C_MORE:     take = stat.more;
            default:    take = 1'b1;
        endcase
        upc_next = take ? word.target : upc_reg + upc_t'(1);
        ctrl.op   = word.op;
        ctrl.idle = (upc_reg == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end
endmodule

// ----- rtl/bsc_datapath.sv -----
// Datapath: matrix store, working vector, flags, sequence buffer and result register.
module bsc_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bsc_in_if.sink                               request,
    bsc_out_if.source                            result,
    input  logic                                 cfg_we,
    input  logic [bsc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bsc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  bsc_pkg::ctrl_t                       ctrl,
    output bsc_pkg::stat_t                       stat
);
    import bsc_pkg::*;

    logic [NPROC_CFG_BITS-1:0] nproc_reg;
    logic [NRES_CFG_BITS-1:0]  nres_reg;

    logic [AVAIL_BITS-1:0]    wa_reg [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] finished_reg;
    logic [PROC_BITS-1:0]     seq_reg [MAX_PROCESSES];

    logic [PROC_BITS-1:0] i_reg;
    logic [RES_BITS-1:0]  j_reg;
    logic [DONE_BITS-1:0] done_reg;
    logic [PROC_BITS-1:0] optr_reg;
    logic                 flag_reg;
    logic                 progress_reg;
    logic                 last_sent_reg;

    logic                 out_valid_reg;
    logic [PROC_BITS-1:0] process_id_reg;
    logic                 status_reg;
    logic                 last_reg;

    logic [NPROC_CFG_BITS-1:0] n_eff;
    logic [NRES_CFG_BITS-1:0]  m_eff;
    logic [PROC_BITS-1:0]      n_last;
    logic [RES_BITS-1:0]       m_last;

    logic                  accept;
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_addr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [ENTRY_BITS-1:0] ram_rdata;
    logic [NEED_BITS-1:0]  need_wr;
    logic [NEED_BITS-1:0]  need_rd;
    logic [COUNT_BITS-1:0] alloc_rd;

    logic [AVAIL_BITS:0]   rel_sum;
    logic [AVAIL_BITS-1:0] wa_rel_next;
    logic                  fits;
    logic                  can_load;
    logic [PROC_BITS-1:0]  i_next;
    logic [RES_BITS-1:0]   j_next;

    // Register values outside their range are clamped when used.
    always_comb
    begin
        if (nproc_reg == '0)
            n_eff = NPROC_CFG_BITS'(1);
        else if (nproc_reg > NPROC_CFG_BITS'(MAX_PROCESSES))
            n_eff = NPROC_CFG_BITS'(MAX_PROCESSES);
        else
            n_eff = nproc_reg;
        if (nres_reg == '0)
            m_eff = NRES_CFG_BITS'(1);
        else if (nres_reg > NRES_CFG_BITS'(MAX_RESOURCES))
            m_eff = NRES_CFG_BITS'(MAX_RESOURCES);
        else
            m_eff = nres_reg;
    end

    assign n_last = PROC_BITS'(n_eff - NPROC_CFG_BITS'(1));
    assign m_last = RES_BITS'(m_eff - NRES_CFG_BITS'(1));

    assign request.ready = ctrl.idle;
    assign accept        = request.valid && ctrl.idle;

    // Each store entry holds the need (demand minus allocation) and the allocation.
    assign need_wr   = {1'b0, request.max_demand} - {1'b0, request.allocated};
    assign ram_wdata = {need_wr, request.allocated};
    assign ram_we    = accept && (request.command == CMD_LOAD_PAIR);
    assign ram_addr  = ctrl.idle ? {request.proc_index, request.res_index} : {i_reg, j_reg};
    assign need_rd   = ram_rdata[ENTRY_BITS-1:COUNT_BITS];
    assign alloc_rd  = ram_rdata[COUNT_BITS-1:0];

    bsc_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_addr),
        .wr_data(ram_wdata),
        .rd_addr(ram_addr),
        .rd_data(ram_rdata)
    );

    // A negative need always fits, so the comparison is done signed.
    assign fits = $signed({{(AVAIL_BITS + 1 - NEED_BITS){need_rd[NEED_BITS-1]}}, need_rd})
                  <= $signed({1'b0, wa_reg[j_reg]});

    assign rel_sum     = {1'b0, wa_reg[j_reg]} + (AVAIL_BITS + 1)'(alloc_rd);
    assign wa_rel_next = rel_sum[AVAIL_BITS] ? '1 : rel_sum[AVAIL_BITS-1:0];

    assign i_next   = (i_reg == n_last) ? '0 : i_reg + PROC_BITS'(1);
    assign j_next   = (j_reg == m_last) ? '0 : j_reg + RES_BITS'(1);
    assign can_load = !out_valid_reg || result.ready;

    always_comb
    begin
        stat.run_start = accept && (request.command == CMD_RUN);
        stat.j_last    = (j_reg == m_last);
        stat.i_last    = (i_reg == n_last);
        stat.flag      = flag_reg;
        stat.fin_i     = finished_reg[i_reg];
        stat.done_all  = (done_reg == DONE_BITS'(n_eff));
        stat.progress  = progress_reg;
        stat.out_stall = !can_load;
        stat.more      = !last_sent_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nproc_reg     <= NPROC_RESET;
            nres_reg      <= NRES_RESET;
            finished_reg  <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            done_reg      <= '0;
            optr_reg      <= '0;
            flag_reg      <= 1'b0;
            progress_reg  <= 1'b0;
            last_sent_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < MAX_RESOURCES; r++)
            begin
                wa_reg[r] <= '0;
            end
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_NUM_PROCESSES))
                nproc_reg <= cfg_data[NPROC_CFG_BITS-1:0];
            if (cfg_we && (cfg_index == REG_NUM_RESOURCES))
                nres_reg <= cfg_data[NRES_CFG_BITS-1:0];

            if (accept && (request.command == CMD_LOAD_AVAIL))
                wa_reg[request.res_index] <= AVAIL_BITS'(request.avail_count);

            if ((ctrl.op == OP_EMIT_SEQ || ctrl.op == OP_EMIT_DEAD) && can_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            case (ctrl.op)
                OP_INIT:
                begin
                    finished_reg <= '0;
                    i_reg        <= '0;
                    j_reg        <= '0;
                    done_reg     <= '0;
                    flag_reg     <= 1'b0;
                end
                OP_HOLD_ACC:
                begin
                    if (alloc_rd != '0)
                        flag_reg <= 1'b1;
                    j_reg <= j_next;
                end
                OP_HOLD_END:
                begin
                    // A process holding nothing is finished up front.
                    if (!flag_reg)
                    begin
                        finished_reg[i_reg] <= 1'b1;
                        done_reg            <= done_reg + DONE_BITS'(1);
                    end
                    flag_reg <= 1'b0;
                    i_reg    <= i_next;
                    j_reg    <= '0;
                end
                OP_PASS_START:
                begin
                    progress_reg <= 1'b0;
                    i_reg        <= '0;
                    j_reg        <= '0;
                    flag_reg     <= 1'b1;
                end
                OP_FIT_ACC:
                begin
                    if (!fits)
                        flag_reg <= 1'b0;
                    j_reg <= j_next;
                end
                OP_RELEASE:
                begin
                    wa_reg[j_reg] <= wa_rel_next;
                    j_reg         <= j_next;
                end
                OP_FINISH:
                begin
                    finished_reg[i_reg] <= 1'b1;
                    done_reg            <= done_reg + DONE_BITS'(1);
                    progress_reg        <= 1'b1;
                end
                OP_NEXT_I:
                begin
                    i_reg    <= i_next;
                    j_reg    <= '0;
                    flag_reg <= 1'b1;
                end
                OP_OUT_INIT:
                begin
                    optr_reg <= '0;
                end
                OP_EMIT_SEQ:
                begin
                    if (can_load)
                    begin
                        last_sent_reg <= (optr_reg == n_last);
                        optr_reg      <= optr_reg + PROC_BITS'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequence buffer and result payload carry no reset.
    always_ff @(posedge clk)
    begin
        if ((ctrl.op == OP_HOLD_END && !flag_reg) || ctrl.op == OP_FINISH)
            seq_reg[done_reg[PROC_BITS-1:0]] <= i_reg;
        if (ctrl.op == OP_EMIT_SEQ && can_load)
        begin
            process_id_reg <= seq_reg[optr_reg];
            status_reg     <= 1'b0;
            last_reg       <= (optr_reg == n_last);
        end
        else if (ctrl.op == OP_EMIT_DEAD && can_load)
        begin
            process_id_reg <= '0;
            status_reg     <= 1'b1;
            last_reg       <= 1'b1;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.process_id = process_id_reg;
    assign result.status     = status_reg;
    assign result.last       = last_reg;
endmodule

// ----- rtl/bankers_safety_check.sv -----
// Loads are accepted back to back; a run takes a set-up step, a scan of the allocations and
// up to n passes over the store (two steps per store entry through the single RAM read
// port), then emits the sequence or a deadlock result, stalling under back-pressure.
// Commands are accepted again once the last result is in the output register. Reset
// (asynchronous, active low) clears the working vector and flags and sets 16 processes and
// 8 resources; the demand and allocation store is not cleared.
module bankers_safety_check (
    input  logic                               clk,
    input  logic                               rst_n,
    bsc_in_if.sink                             request,
    bsc_out_if.source                          result,
    input  logic                               cfg_we,
    input  logic [bsc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bsc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import bsc_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    bsc_sequencer u_sequencer (
        .clk  (clk),
        .rst_n(rst_n),
        .stat (stat),
        .ctrl (ctrl)
    );

    bsc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .ctrl     (ctrl),
        .stat     (stat)
    );
endmodule
